[design/spn_pkg.sv]
// Shared types, constants and helpers for the subset-product neuron evaluator.
// Holds the request kinds, the sequencer states, the coefficient word and the decay ROM.
// No dependencies.
package spn_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int NUM_PORTS = 4;
  localparam int ACT_W     = 3;
  localparam int ROM_LAST  = 201;
  localparam int ROM_SIZE  = ROM_LAST + 1;
  localparam int ROM_W     = FRAC_BITS + 1;
  localparam int RIW       = $clog2(ROM_SIZE);
  localparam int TERM_W    = DW + 2;
  localparam int RND_W     = 40;

  localparam logic signed [DW-1:0]    ONE_Q   = DW'(1 << FRAC_BITS);
  localparam logic signed [RND_W-1:0] HALF_R  = RND_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [RND_W-1:0] ONE_R   = RND_W'(1 << FRAC_BITS);
  localparam logic signed [RND_W-1:0] NONE_R  = -ONE_R;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_EVAL    = 2'd1,
    KIND_MUTATE  = 2'd2,
    KIND_RESTORE = 2'd3
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MUT_RD,
    ST_MUT_WR,
    ST_EV_RD,
    ST_EV_PROD,
    ST_EV_ABS,
    ST_EV_SCALE,
    ST_EV_INTERP,
    ST_EV_YSUM,
    ST_EV_TERM,
    ST_EV_ACC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [DW-1:0] amp;
    logic signed [DW-1:0] off;
  } coeff_t;

  typedef struct packed {
    logic abs_en;
    logic scale_en;
    logic interp_en;
    logic ysum_en;
    logic term_en;
  } term_ctl_t;

  typedef logic [ROM_W-1:0] rom_arr_t [ROM_SIZE];

  localparam int DECAY_RAW [ROM_SIZE] = '{
    10000, 9951, 9720, 9358, 8895, 8363, 7794, 7214, 6644, 6098,
    5586, 5111, 4677, 4282, 3924, 3601, 3311, 3049, 2814, 2602,
    2411, 2238, 2082, 1941, 1813, 1696, 1590, 1493, 1405, 1324,
    1249, 1181, 1117, 1059, 1005, 955, 909, 866, 826, 789,
    754, 721, 691, 662, 635, 610, 586, 564, 543, 523,
    504, 487, 470, 454, 439, 424, 411, 398, 385, 374,
    362, 352, 341, 332, 322, 313, 305, 296, 288, 281,
    274, 267, 260, 253, 247, 241, 235, 230, 224, 219,
    214, 209, 204, 200, 195, 191, 187, 182, 178, 175,
    171, 167, 164, 160, 157, 154, 150, 147, 144, 141,
    138, 135, 133, 130, 127, 125, 122, 120, 117, 115,
    112, 110, 108, 105, 103, 101, 99, 97, 95, 93,
    91, 89, 87, 85, 83, 81, 79, 77, 75, 72,
    71, 70, 69, 68, 67, 66, 65, 64, 63, 62,
    61, 60, 59, 58, 57, 56, 55, 54, 53, 52,
    51, 50, 49, 48, 47, 46, 45, 44, 43, 42,
    41, 40, 39, 38, 37, 36, 35, 34, 33, 32,
    31, 30, 29, 28, 27, 26, 25, 24, 23, 22,
    21, 20, 19, 18, 17, 16, 15, 14, 13, 12,
    11, 10, 9, 8, 7, 6, 5, 4, 3, 2,
    1, 0
  };

  function automatic rom_arr_t build_decay();
    rom_arr_t r;
    for (int k = 0; k < ROM_SIZE; k++) begin
      r[k] = ROM_W'((DECAY_RAW[k] * (1 << FRAC_BITS) + 5000) / 10000);
    end
    return r;
  endfunction

  localparam rom_arr_t DECAY_Q = build_decay();

  function automatic logic signed [RND_W-1:0] rnd_q(input logic signed [RND_W-1:0] x);
    return (x + HALF_R) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [DW-1:0] clamp_one(input logic signed [RND_W-1:0] x);
    logic signed [DW-1:0] r;
    if (x > ONE_R) begin
      r = ONE_Q;
    end else if (x < NONE_R) begin
      r = -ONE_Q;
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

endpackage

[design/spn_coeff_mem.sv]
// Coefficient pair memory: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on spn_pkg.
module spn_coeff_mem #(
  parameter int AW = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  spn_pkg::coeff_t      wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output spn_pkg::coeff_t      rdata
);

  localparam int DEPTH = 1 << AW;

  spn_pkg::coeff_t mem [DEPTH];
  spn_pkg::coeff_t rd_raw;
  logic [DEPTH-1:0] valid;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_raw : '0;

endmodule

[design/spn_term_calc.sv]
// One coefficient term: |product + offset| scaled by 100, decay ROM interpolation,
// then scaling by the amplitude. Each step is registered under a strobe from the sequencer.
// Depends on spn_pkg.
module spn_term_calc #(
  parameter int PW = 20
) (
  input  logic                                clk,
  input  spn_pkg::term_ctl_t                  ctl,
  input  logic signed [PW-1:0]                p,
  input  spn_pkg::coeff_t                     coeff,
  output logic signed [spn_pkg::TERM_W-1:0]   term
);

  localparam int SW  = PW + 1;
  localparam int TSW = SW + 7;
  localparam int KW  = TSW - spn_pkg::FRAC_BITS;
  localparam int DPW = spn_pkg::ROM_W + 1 + spn_pkg::FRAC_BITS + 1;
  localparam int YW  = spn_pkg::ROM_W + 2;
  localparam int MW  = YW + spn_pkg::DW;

  logic signed [SW-1:0]                  sum_po;
  logic [SW-1:0]                         a_next;
  logic [SW-1:0]                         a_r;
  logic [TSW-1:0]                        t;
  logic [KW-1:0]                         k;
  logic                                  past_next;
  logic [spn_pkg::RIW-1:0]               k_r;
  logic [spn_pkg::FRAC_BITS-1:0]         f_r;
  logic                                  past_r;
  logic [spn_pkg::ROM_W-1:0]             ya;
  logic [spn_pkg::ROM_W-1:0]             yb;
  logic signed [spn_pkg::ROM_W:0]        diff;
  logic signed [DPW-1:0]                 d_next;
  logic [spn_pkg::ROM_W-1:0]             ya_r;
  logic signed [DPW-1:0]                 d_r;
  logic signed [spn_pkg::RND_W-1:0]      d_rnd;
  logic signed [YW-1:0]                  y_next;
  logic signed [YW-1:0]                  y_r;
  logic signed [MW-1:0]                  ym;
  logic signed [spn_pkg::RND_W-1:0]      ym_rnd;

  assign sum_po    = SW'(p) + SW'(coeff.off);
  assign a_next    = sum_po[SW-1] ? SW'(-sum_po) : SW'(sum_po);
  assign t         = TSW'(a_r) * TSW'(100);
  assign k         = t[TSW-1:spn_pkg::FRAC_BITS];
  assign past_next = (k >= KW'(spn_pkg::ROM_LAST));

  assign ya     = spn_pkg::DECAY_Q[k_r];
  assign yb     = spn_pkg::DECAY_Q[spn_pkg::RIW'(k_r + 1'b1)];
  assign diff   = $signed({1'b0, yb}) - $signed({1'b0, ya});
  assign d_next = DPW'(diff) * DPW'($signed({1'b0, f_r}));

  assign d_rnd  = spn_pkg::rnd_q(spn_pkg::RND_W'(d_r));
  assign y_next = past_r ? '0 : YW'($signed({1'b0, ya_r})) + d_rnd[YW-1:0];

  assign ym     = MW'(y_r) * MW'(coeff.amp);
  assign ym_rnd = spn_pkg::rnd_q(spn_pkg::RND_W'(ym));

  always_ff @(posedge clk) begin
    if (ctl.abs_en) begin
      a_r <= a_next;
    end
    if (ctl.scale_en) begin
      k_r    <= past_next ? spn_pkg::RIW'(spn_pkg::ROM_LAST - 1) : k[spn_pkg::RIW-1:0];
      f_r    <= t[spn_pkg::FRAC_BITS-1:0];
      past_r <= past_next;
    end
    if (ctl.interp_en) begin
      ya_r <= ya;
      d_r  <= d_next;
    end
    if (ctl.ysum_en) begin
      y_r <= y_next;
    end
    if (ctl.term_en) begin
      term <= ym_rnd[spn_pkg::TERM_W-1:0];
    end
  end

endmodule

[design/subset_product_neuron_eval.sv]
// Top level of the subset-product neuron evaluator: request sequencer, input product
// chain and accumulator around the coefficient memory and the term unit.
// Depends on spn_pkg, spn_coeff_mem and spn_term_calc.
//
// Usage:
//   Requests enter on start while busy is low; all request fields are sampled at that edge.
//   Each request gives exactly one result: done is high for one cycle with neuron_out and
//   done_kind; the receiver cannot stall it and must take it in that cycle.
//   active_inputs is written through cfg_valid/cfg_data (cfg_ready is always high); the user
//   must write it only while the block is idle, which the block itself does not enforce.
// Steps, from the accepting edge to the cycle in which done is high:
//   load and restore write one entry, mutate reads, modifies and writes back one entry,
//   and evaluate runs one pass per term over all 2^n terms for n active inputs: each
//   term takes one memory read, n product steps on the shared multiplier and the steps
//   of offset, ROM interpolation, amplitude scaling and accumulation; then done is raised.
//   busy drops in the cycle after done.
// Reset: all coefficient pairs and the saved pair read as zero, active_inputs is 4,
//   no result is pending.
module subset_product_neuron_eval #(
  parameter int MAX_INPUTS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic signed [15:0]           in_0,
  input  logic signed [15:0]           in_1,
  input  logic signed [15:0]           in_2,
  input  logic signed [15:0]           in_3,
  input  logic [3:0]                   coeff_index,
  input  logic signed [15:0]           amp_value,
  input  logic signed [15:0]           offset_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spn_pkg::ACT_W-1:0]    cfg_data,
  output logic                         done,
  output logic signed [15:0]           neuron_out,
  output logic [1:0]                   done_kind
);

  localparam int AW    = MAX_INPUTS;
  localparam int PW    = spn_pkg::FRAC_BITS + MAX_INPUTS + 2;
  localparam int PMW   = PW + spn_pkg::DW;
  localparam int ACC_W = spn_pkg::TERM_W + MAX_INPUTS;

  spn_pkg::state_t     state;
  spn_pkg::state_t     state_next;
  spn_pkg::req_kind_t  kind_r;
  spn_pkg::term_ctl_t  term_ctl;
  spn_pkg::coeff_t     rdata;
  spn_pkg::coeff_t     wdata;
  spn_pkg::coeff_t     saved_pair;

  logic signed [spn_pkg::DW-1:0]     x_r [spn_pkg::NUM_PORTS];
  logic [AW-1:0]                     idx_r;
  logic signed [spn_pkg::DW-1:0]     amp_in_r;
  logic signed [spn_pkg::DW-1:0]     off_in_r;
  logic [spn_pkg::ACT_W-1:0]         active_inputs;
  logic [spn_pkg::ACT_W-1:0]         n_eff;
  logic [AW-1:0]                     i_r;
  logic [AW-1:0]                     sel_r;
  logic [1:0]                        j_r;
  logic signed [PW-1:0]              p_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           acc_sum;
  logic signed [spn_pkg::DW-1:0]     result_r;
  logic [AW-1:0]                     saved_index;
  logic signed [spn_pkg::TERM_W-1:0] term;

  logic                              accept;
  logic                              prod_last;
  logic                              term_last;
  logic [AW:0]                       term_cnt;
  logic [AW:0]                       term_lim;
  logic signed [PMW-1:0]             pm;
  logic signed [spn_pkg::RND_W-1:0]  p_step;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign n_eff = (active_inputs > spn_pkg::ACT_W'(MAX_INPUTS)) ?
                 spn_pkg::ACT_W'(MAX_INPUTS) : active_inputs;

  assign prod_last = (spn_pkg::ACT_W'(j_r) + spn_pkg::ACT_W'(1)) == n_eff;
  assign term_cnt  = (AW + 1)'(i_r) + (AW + 1)'(1);
  assign term_lim  = (AW + 1)'(1) << n_eff;
  assign term_last = (term_cnt == term_lim);

  assign pm      = PMW'(p_r) * PMW'(x_r[j_r]);
  assign p_step  = spn_pkg::rnd_q(spn_pkg::RND_W'(pm));
  assign acc_sum = acc_r + ACC_W'(term);

  spn_coeff_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  spn_term_calc #(
    .PW (PW)
  ) u_term (
    .clk   (clk),
    .ctl   (term_ctl),
    .p     (p_r),
    .coeff (rdata),
    .term  (term)
  );

  always_comb begin
    state_next = state;
    case (state)
      spn_pkg::ST_IDLE: begin
        if (start) begin
          case (spn_pkg::req_kind_t'(req_type))
            spn_pkg::KIND_EVAL:   state_next = spn_pkg::ST_EV_RD;
            spn_pkg::KIND_MUTATE: state_next = spn_pkg::ST_MUT_RD;
            default:              state_next = spn_pkg::ST_WRITE;
          endcase
        end
      end
      spn_pkg::ST_WRITE:     state_next = spn_pkg::ST_RESULT;
      spn_pkg::ST_MUT_RD:    state_next = spn_pkg::ST_MUT_WR;
      spn_pkg::ST_MUT_WR:    state_next = spn_pkg::ST_RESULT;
      spn_pkg::ST_EV_RD: begin
        state_next = (n_eff == '0) ? spn_pkg::ST_EV_ABS : spn_pkg::ST_EV_PROD;
      end
      spn_pkg::ST_EV_PROD: begin
        if (prod_last) begin
          state_next = spn_pkg::ST_EV_ABS;
        end
      end
      spn_pkg::ST_EV_ABS:    state_next = spn_pkg::ST_EV_SCALE;
      spn_pkg::ST_EV_SCALE:  state_next = spn_pkg::ST_EV_INTERP;
      spn_pkg::ST_EV_INTERP: state_next = spn_pkg::ST_EV_YSUM;
      spn_pkg::ST_EV_YSUM:   state_next = spn_pkg::ST_EV_TERM;
      spn_pkg::ST_EV_TERM:   state_next = spn_pkg::ST_EV_ACC;
      spn_pkg::ST_EV_ACC: begin
        state_next = term_last ? spn_pkg::ST_RESULT : spn_pkg::ST_EV_RD;
      end
      spn_pkg::ST_RESULT:    state_next = spn_pkg::ST_IDLE;
      default:               state_next = spn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy               = (state != spn_pkg::ST_IDLE);
    done               = (state == spn_pkg::ST_RESULT);
    term_ctl.abs_en    = (state == spn_pkg::ST_EV_ABS);
    term_ctl.scale_en  = (state == spn_pkg::ST_EV_SCALE);
    term_ctl.interp_en = (state == spn_pkg::ST_EV_INTERP);
    term_ctl.ysum_en   = (state == spn_pkg::ST_EV_YSUM);
    term_ctl.term_en   = (state == spn_pkg::ST_EV_TERM);
    mem_we             = (state == spn_pkg::ST_WRITE) || (state == spn_pkg::ST_MUT_WR);
    mem_re             = (state == spn_pkg::ST_MUT_RD) || (state == spn_pkg::ST_EV_RD);
    mem_raddr          = (state == spn_pkg::ST_EV_RD) ? i_r : idx_r;
    mem_waddr          = idx_r;
    wdata.amp          = amp_in_r;
    wdata.off          = off_in_r;
    if (state == spn_pkg::ST_MUT_WR) begin
      wdata.amp = spn_pkg::clamp_one(spn_pkg::RND_W'(rdata.amp) + spn_pkg::RND_W'(amp_in_r));
      wdata.off = spn_pkg::clamp_one(spn_pkg::RND_W'(rdata.off) + spn_pkg::RND_W'(off_in_r));
    end else if (kind_r == spn_pkg::KIND_RESTORE) begin
      mem_waddr = saved_index;
      wdata     = saved_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spn_pkg::ST_IDLE;
      active_inputs <= spn_pkg::ACT_W'(4);
      saved_index   <= '0;
      saved_pair    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_inputs <= cfg_data;
      end
      if (state == spn_pkg::ST_MUT_WR) begin
        saved_index <= idx_r;
        saved_pair  <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= spn_pkg::req_kind_t'(req_type);
      x_r[0]   <= in_0;
      x_r[1]   <= in_1;
      x_r[2]   <= in_2;
      x_r[3]   <= in_3;
      idx_r    <= coeff_index[AW-1:0];
      amp_in_r <= amp_value;
      off_in_r <= offset_value;
      i_r      <= '0;
      acc_r    <= '0;
      result_r <= '0;
    end
    case (state)
      spn_pkg::ST_EV_RD: begin
        p_r   <= (i_r == '0) ? '0 : PW'(spn_pkg::ONE_Q);
        sel_r <= i_r;
        j_r   <= '0;
      end
      spn_pkg::ST_EV_PROD: begin
        if (sel_r[0]) begin
          p_r <= p_step[PW-1:0];
        end
        sel_r <= sel_r >> 1;
        j_r   <= j_r + 2'd1;
      end
      spn_pkg::ST_EV_ACC: begin
        acc_r <= acc_sum;
        i_r   <= i_r + 1'b1;
        if (term_last) begin
          result_r <= spn_pkg::clamp_one(spn_pkg::RND_W'(acc_sum));
        end
      end
      default: begin
      end
    endcase
  end

  assign neuron_out = result_r;
  assign done_kind  = kind_r;

`ifndef NO_ASSERTIONS
  a_single_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_zero_non_eval: assert property (@(posedge clk) disable iff (rst)
    (done && done_kind != spn_pkg::KIND_EVAL) |-> (neuron_out == '0))
    else $error("non-evaluate result not zero");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((neuron_out <= spn_pkg::ONE_Q) && (neuron_out >= -spn_pkg::ONE_Q)))
    else $error("neuron output outside clamp range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("request accepted without going busy");
`endif

endmodule
